### hw/rtl/bdil_pkg.sv
// ----------------------------------------------------------------------------
// Bitstring difference index lister: shared definitions
// Field widths, the stream packing layout and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdil_pkg;

    // Occupation word geometry.
    localparam int WORD_BITS  = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int WORD_POS_W = 4;

    // Words at or above this position are dropped.
    localparam int MAX_WORDS  = 16;

    // Result field widths and the running count width.
    localparam int INDEX_W    = 10;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 24;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the input beat into the scan registers
        logic emit;   // list the next differing bit into the output register
    } bdil_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic load_empty;  // the beat at the input causes no result
        logic work_left;   // differing bits remain in the scan registers
        logic last_bit;    // the bit chosen now is the last of this word
        logic out_free;    // the output register can take a result this cycle
    } bdil_status_t;

endpackage

`default_nettype wire

### hw/rtl/bdil_datapath.sv
// ----------------------------------------------------------------------------
// Bitstring difference index lister: datapath
// Holds the creation and annihilation masks of one word, picks the highest
// remaining bit each step, keeps the running counts and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdil_datapath
    import bdil_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bdil_cmd_t            cmd,
    output bdil_status_t              status,
    // Input beat, lowest bit up: word_position, bra_bits, ket_bits, padding.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // Input flag: new_pair.
    input  wire logic                 s_tuser,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    // Result beat, lowest bit up: orbital_index, list_slot, padding.
    output logic [M_TDATA_W-1:0]      m_tdata,
    // Result kind: is_creation.
    output logic                      m_tuser,
    output logic                      m_tlast
);

    // Index of the highest set bit; zero when no bit is set.
    function automatic logic [BIT_IDX_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // Unpack the input beat.
    logic [WORD_POS_W-1:0] in_word;
    logic [WORD_BITS-1:0]  in_bra;
    logic [WORD_BITS-1:0]  in_ket;
    logic                  in_range;
    logic [WORD_BITS-1:0]  in_cre;
    logic [WORD_BITS-1:0]  in_ann;

    assign in_word  = s_tdata[WORD_POS_W-1:0];
    assign in_bra   = s_tdata[WORD_POS_W +: WORD_BITS];
    assign in_ket   = s_tdata[WORD_POS_W+WORD_BITS +: WORD_BITS];
    assign in_range = (32'(in_word) < MAX_WORDS);
    assign in_cre   = in_range ? (in_bra & ~in_ket) : '0;
    assign in_ann   = in_range ? (in_ket & ~in_bra) : '0;

    // Scan registers and running counts.
    logic [WORD_BITS-1:0]  cre_reg, cre_next;
    logic [WORD_BITS-1:0]  ann_reg, ann_next;
    logic [WORD_POS_W-1:0] word_reg, word_next;
    logic [COUNT_W-1:0]    cre_cnt_reg, cre_cnt_next;
    logic [COUNT_W-1:0]    ann_cnt_reg, ann_cnt_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]    m_index_reg, m_index_next;
    logic [SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic                  m_cre_reg, m_cre_next;
    logic                  m_last_reg, m_last_next;

    // Selection of the next bit: creation bits go first.
    logic                  sel_cre;
    logic [WORD_BITS-1:0]  cur_mask;
    logic [BIT_IDX_W-1:0]  cur_bit;
    logic [WORD_BITS-1:0]  cur_cleared;
    logic                  cur_last;

    assign sel_cre     = |cre_reg;
    assign cur_mask    = sel_cre ? cre_reg : ann_reg;
    assign cur_bit     = top_bit(cur_mask);
    assign cur_cleared = cur_mask & ~(WORD_BITS'(1) << cur_bit);
    assign cur_last    = sel_cre ? ((cur_cleared == '0) && (ann_reg == '0))
                                 : (cur_cleared == '0);

    // Status to the controller.
    assign status.load_empty = (in_cre == '0) && (in_ann == '0);
    assign status.work_left  = (cre_reg != '0) || (ann_reg != '0);
    assign status.last_bit   = cur_last;
    assign status.out_free   = !m_valid_reg || m_tready;

    // Next-state logic for the scan registers, counts and output register.
    always_comb begin
        cre_next     = cre_reg;
        ann_next     = ann_reg;
        word_next    = word_reg;
        cre_cnt_next = cre_cnt_reg;
        ann_cnt_next = ann_cnt_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_slot_next  = m_slot_reg;
        m_cre_next   = m_cre_reg;
        m_last_next  = m_last_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            cre_next  = in_cre;
            ann_next  = in_ann;
            word_next = in_word;
            if (s_tuser) begin
                cre_cnt_next = '0;
                ann_cnt_next = '0;
            end
        end else if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_index_next = {word_reg, cur_bit};
            m_cre_next   = sel_cre;
            m_last_next  = cur_last;
            if (sel_cre) begin
                cre_next     = cur_cleared;
                m_slot_next  = cre_cnt_reg[SLOT_W-1:0];
                cre_cnt_next = cre_cnt_reg + COUNT_W'(1);
            end else begin
                ann_next     = cur_cleared;
                m_slot_next  = ann_cnt_reg[SLOT_W-1:0];
                ann_cnt_next = ann_cnt_reg + COUNT_W'(1);
            end
        end
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cre_reg     <= '0;
            ann_reg     <= '0;
            cre_cnt_reg <= '0;
            ann_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cre_reg     <= cre_next;
            ann_reg     <= ann_next;
            cre_cnt_reg <= cre_cnt_next;
            ann_cnt_reg <= ann_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        m_index_reg <= m_index_next;
        m_slot_reg  <= m_slot_next;
        m_cre_reg   <= m_cre_next;
        m_last_reg  <= m_last_next;
    end

    // Result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-INDEX_W-SLOT_W)'(0), m_slot_reg, m_index_reg};
    assign m_tuser  = m_cre_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### hw/rtl/bdil_ctrl.sv
// ----------------------------------------------------------------------------
// Bitstring difference index lister: controller
// Takes one input beat when idle, then steps the datapath through the
// differing bits of that word, one result per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bdil_ctrl
    import bdil_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire bdil_status_t status,
    output bdil_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    // Commands to the datapath.
    assign cmd.load = accept;
    assign cmd.emit = (state_reg == ST_SCAN) && status.work_left && status.out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !status.load_empty) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!status.work_left || (cmd.emit && status.last_bit)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bitstring_difference_index_lister.sv
// ----------------------------------------------------------------------------
// Bitstring difference index lister
// Lists the bit positions where a bra and a ket occupation word differ:
// creation positions first, then annihilation positions, each from high to low.
// ----------------------------------------------------------------------------
//
//  Channel | Beat carries                                  | Sideband
//  --------+-----------------------------------------------+-------------------------
//  s_axis  | tdata: word_position, bra_bits, ket_bits      | tuser: new_pair
//  m_axis  | tdata: orbital_index, list_slot               | tuser: is_creation,
//          |                                               | tlast: last_of_word
//
// A word with differing bits is loaded, then listed one result at a time by the
// single highest-bit picker in the datapath. A word with no differing bits, or
// beyond the supported word count, is taken without entering the scan state.
// Reset is synchronous and active low; it clears both running counts.
// A stalled output holds the picker; the input is not ready until the current
// word has been fully listed into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bitstring_difference_index_lister
    import bdil_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // Lowest bit up: word_position[3:0], bra_bits[67:4], ket_bits[131:68], zeros.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // new_pair.
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Lowest bit up: orbital_index[9:0], list_slot[19:10], zeros.
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // is_creation.
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    bdil_cmd_t    cmd;
    bdil_status_t status;

    bdil_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdil_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

    // Loading and listing never happen in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.emit))
        else $error("load and emit issued together");

    // A beat that causes results closes the input until it is listed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !status.load_empty) |=> !s_axis_tready)
        else $error("input still ready while a word is being listed");

    // The last result of a word reopens the input on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.last_bit) |=> s_axis_tready)
        else $error("input not reopened after the last result of a word");

    // A result marked last of word leaves nothing to list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.last_bit) |=> !status.work_left)
        else $error("bits remain after the last result of a word");

endmodule

`default_nettype wire
